[rtl/rpac_pkg.sv]
package rpac_pkg;

  localparam int PW = 24;
  localparam int CW = 32;
  localparam int TW = 32;
  localparam int QS = 30;
  localparam int PRODW = CW + TW;
  localparam int SUMW = PRODW + 1;
  localparam int CFGW = 64;
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] REG_TRIG_X = 3'd0;
  localparam logic [IDXW-1:0] REG_TRIG_Y = 3'd1;
  localparam logic [IDXW-1:0] REG_TRIG_Z = 3'd2;
  localparam logic [IDXW-1:0] REG_PIVOT_X = 3'd3;
  localparam logic [IDXW-1:0] REG_PIVOT_Y = 3'd4;
  localparam logic [IDXW-1:0] REG_PIVOT_Z = 3'd5;

  localparam logic [CFGW-1:0] TRIG_RESET = 64'h4000_0000_0000_0000;

  localparam logic signed [PW:0] SAT_HI = 25'sd8388607;
  localparam logic signed [PW:0] SAT_LO = -25'sd8388608;
  localparam logic signed [SUMW-1:0] HALF_LSB = 65'sh2000_0000;

  typedef logic signed [PW-1:0] pos_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
  } trig_t;

  // a, b are rotated, p passes through
  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t p;
  } cell_data_t;

  function automatic coord_t round_q30(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    begin
      t = v + HALF_LSB;
      return coord_t'(t[QS+CW-1:QS]);
    end
  endfunction

  function automatic pos_t saturate(input coord_t v, input pos_t piv);
    logic signed [CW:0] r;
    begin
      r = {v[CW-1], v} + {{(CW-PW+1){piv[PW-1]}}, piv};
      if (r > $signed({{(CW-PW){SAT_HI[PW]}}, SAT_HI})) begin
        return SAT_HI[PW-1:0];
      end else if (r < $signed({{(CW-PW){SAT_LO[PW]}}, SAT_LO})) begin
        return SAT_LO[PW-1:0];
      end else begin
        return r[PW-1:0];
      end
    end
  endfunction

endpackage

[rtl/rpac_cell.sv]
module rpac_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rpac_pkg::trig_t     trig,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpac_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rpac_pkg::cell_data_t out_data
);
  import rpac_pkg::*;

  logic v1_r, v2_r;
  logic en1, en2;
  logic signed [PRODW-1:0] ca_r, sb_r, sa_r, cb_r;
  coord_t pass_r;
  cell_data_t data_r;
  logic signed [SUMW-1:0] diff_nxt, sum_nxt;
  cell_data_t data_nxt;

  always_comb begin
    en2 = !v2_r || out_ready;
    en1 = !v1_r || en2;
  end

  // a' = c*a - s*b, b' = s*a + c*b
  always_comb begin
    diff_nxt = {ca_r[PRODW-1], ca_r} - {sb_r[PRODW-1], sb_r};
    sum_nxt  = {sa_r[PRODW-1], sa_r} + {cb_r[PRODW-1], cb_r};
    data_nxt.a = round_q30(diff_nxt);
    data_nxt.b = round_q30(sum_nxt);
    data_nxt.p = pass_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ca_r   <= trig.c * in_data.a;
      sb_r   <= trig.s * in_data.b;
      sa_r   <= trig.s * in_data.a;
      cb_r   <= trig.c * in_data.b;
      pass_r <= in_data.p;
    end
    if (en2 && v1_r) begin
      data_r <= data_nxt;
    end
  end

  assign in_ready  = en1;
  assign out_valid = v2_r;
  assign out_data  = data_r;

endmodule

[rtl/point_rotate_about_centroid.sv]
// Rotates a stream of signed Q12.12 points about a configured centroid: the
// centroid is subtracted, the offset is rotated about X, then Y, then Z by the
// configured Q2.30 cosine/sine pairs, and the centroid is added back with
// saturation to 24 bits. One point is taken per clock cycle while the output
// is not held by back-pressure. Each point passes one subtract stage, three
// rotation cells of two stages each for the multiply and the round, and the
// saturating output register. The rotation cells each hold four 32x32
// multipliers. Configuration writes take effect at once; the user must make
// them while no point is in flight, as the block does not enforce this.
module point_rotate_about_centroid (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [71:0]                  in_tdata,   // pos_x, pos_y, pos_z
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [71:0]                  out_tdata,  // rot_x, rot_y, rot_z
  input  logic                         cfg_wr_en,
  input  logic [rpac_pkg::IDXW-1:0]    cfg_index,
  input  logic [rpac_pkg::CFGW-1:0]    cfg_wdata
);
  import rpac_pkg::*;

  logic [CFGW-1:0] trig_x_r, trig_y_r, trig_z_r;
  pos_t pivot_x_r, pivot_y_r, pivot_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_x_r  <= TRIG_RESET;
      trig_y_r  <= TRIG_RESET;
      trig_z_r  <= TRIG_RESET;
      pivot_x_r <= '0;
      pivot_y_r <= '0;
      pivot_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRIG_X:  trig_x_r  <= cfg_wdata;
        REG_TRIG_Y:  trig_y_r  <= cfg_wdata;
        REG_TRIG_Z:  trig_z_r  <= cfg_wdata;
        REG_PIVOT_X: pivot_x_r <= cfg_wdata[PW-1:0];
        REG_PIVOT_Y: pivot_y_r <= cfg_wdata[PW-1:0];
        REG_PIVOT_Z: pivot_z_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  trig_t trig_x, trig_y, trig_z;
  assign trig_x = trig_t'(trig_x_r);
  assign trig_y = trig_t'(trig_y_r);
  assign trig_z = trig_t'(trig_z_r);

  // offset from centroid
  pos_t pos_x, pos_y, pos_z;
  logic signed [PW:0] dx_nxt, dy_nxt, dz_nxt;
  logic front_v_r, front_en;
  logic c0_in_ready;
  cell_data_t front_r;

  assign pos_x = in_tdata[PW-1:0];
  assign pos_y = in_tdata[2*PW-1:PW];
  assign pos_z = in_tdata[3*PW-1:2*PW];

  always_comb begin
    dx_nxt = {pos_x[PW-1], pos_x} - {pivot_x_r[PW-1], pivot_x_r};
    dy_nxt = {pos_y[PW-1], pos_y} - {pivot_y_r[PW-1], pivot_y_r};
    dz_nxt = {pos_z[PW-1], pos_z} - {pivot_z_r[PW-1], pivot_z_r};
    front_en = !front_v_r || c0_in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (front_en) begin
      front_v_r <= in_tvalid;
    end
  end

  // x-axis cell rotates (y, z)
  always_ff @(posedge clk) begin
    if (front_en && in_tvalid) begin
      front_r.a <= {{(CW-PW-1){dy_nxt[PW]}}, dy_nxt};
      front_r.b <= {{(CW-PW-1){dz_nxt[PW]}}, dz_nxt};
      front_r.p <= {{(CW-PW-1){dx_nxt[PW]}}, dx_nxt};
    end
  end

  assign in_tready = front_en;

  logic c0_out_valid, c1_in_ready, c1_out_valid, c2_in_ready, c2_out_valid, back_en;
  cell_data_t c0_out, c1_in, c1_out, c2_in, c2_out;

  rpac_cell u_cell_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig     (trig_x),
    .in_valid (front_v_r),
    .in_ready (c0_in_ready),
    .in_data  (front_r),
    .out_valid(c0_out_valid),
    .out_ready(c1_in_ready),
    .out_data (c0_out)
  );

  // y-axis cell rotates (z, x)
  assign c1_in.a = c0_out.b;
  assign c1_in.b = c0_out.p;
  assign c1_in.p = c0_out.a;

  rpac_cell u_cell_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig     (trig_y),
    .in_valid (c0_out_valid),
    .in_ready (c1_in_ready),
    .in_data  (c1_in),
    .out_valid(c1_out_valid),
    .out_ready(c2_in_ready),
    .out_data (c1_out)
  );

  // z-axis cell rotates (x, y)
  assign c2_in.a = c1_out.b;
  assign c2_in.b = c1_out.p;
  assign c2_in.p = c1_out.a;

  rpac_cell u_cell_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig     (trig_z),
    .in_valid (c1_out_valid),
    .in_ready (c2_in_ready),
    .in_data  (c2_in),
    .out_valid(c2_out_valid),
    .out_ready(back_en),
    .out_data (c2_out)
  );

  // add centroid back and clamp
  logic out_v_r;
  pos_t rot_x_r, rot_y_r, rot_z_r;

  assign back_en = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (back_en) begin
      out_v_r <= c2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en && c2_out_valid) begin
      rot_x_r <= saturate(c2_out.a, pivot_x_r);
      rot_y_r <= saturate(c2_out.b, pivot_y_r);
      rot_z_r <= saturate(c2_out.p, pivot_z_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {rot_z_r, rot_y_r, rot_x_r};

  // items in flight
  logic [3:0] occ_r, occ_nxt;
  logic in_acc, out_acc;

  always_comb begin
    in_acc  = in_tvalid && in_tready;
    out_acc = out_tvalid && out_tready;
    occ_nxt = occ_r + {3'd0, in_acc} - {3'd0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output not blocked");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 4'd8)
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 4'd0) |-> !out_tvalid)
    else $error("result presented with nothing in flight");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 4'd8) |-> (out_tvalid && front_v_r))
    else $error("pipeline full count disagrees with stage valids");

endmodule

[verif/rpac_checker.sv]
module rpac_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [71:0]               in_tdata,   // pos_x, pos_y, pos_z
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [71:0]               out_tdata,  // rot_x, rot_y, rot_z
  input  logic                      cfg_wr_en,
  input  logic [rpac_pkg::IDXW-1:0] cfg_index,
  input  logic [rpac_pkg::CFGW-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        in_flight
);
  import rpac_pkg::*;

  localparam longint POS_HI = 64'sd8388607;
  localparam longint POS_LO = -64'sd8388608;

  typedef struct {
    pos_t x;
    pos_t y;
    pos_t z;
  } point_t;

  trig_t  about_x = TRIG_RESET;
  trig_t  about_y = TRIG_RESET;
  trig_t  about_z = TRIG_RESET;
  pos_t   pivot_x = '0;
  pos_t   pivot_y = '0;
  pos_t   pivot_z = '0;
  point_t rotated_q[$];
  int     errors = 0;

  initial begin
    mismatches = 0;
    in_flight = 0;
  end

  function automatic longint q30_round(input longint p);
    return (p + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic pos_t add_pivot_sat(input longint v, input pos_t piv);
    longint r;
    r = v + longint'(piv);
    if (r > POS_HI) r = POS_HI;
    if (r < POS_LO) r = POS_LO;
    return pos_t'(r);
  endfunction

  function automatic point_t rotate_about_pivot(input point_t p);
    longint x, y, z, c, s, a, b;
    point_t r;
    x = longint'(p.x) - longint'(pivot_x);
    y = longint'(p.y) - longint'(pivot_y);
    z = longint'(p.z) - longint'(pivot_z);
    c = longint'(about_x.c);
    s = longint'(about_x.s);
    a = q30_round(c * y - s * z);
    b = q30_round(s * y + c * z);
    y = a;
    z = b;
    c = longint'(about_y.c);
    s = longint'(about_y.s);
    a = q30_round(c * x + s * z);
    b = q30_round(c * z - s * x);
    x = a;
    z = b;
    c = longint'(about_z.c);
    s = longint'(about_z.s);
    a = q30_round(c * x - s * y);
    b = q30_round(s * x + c * y);
    x = a;
    y = b;
    r.x = add_pivot_sat(x, pivot_x);
    r.y = add_pivot_sat(y, pivot_y);
    r.z = add_pivot_sat(z, pivot_z);
    return r;
  endfunction

  task automatic check_field(input string name, input pos_t want, input pos_t got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    point_t pt;
    point_t want;
    if (!rst_n) begin
      about_x = TRIG_RESET;
      about_y = TRIG_RESET;
      about_z = TRIG_RESET;
      pivot_x = '0;
      pivot_y = '0;
      pivot_z = '0;
      rotated_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TRIG_X:  about_x = trig_t'(cfg_wdata);
          REG_TRIG_Y:  about_y = trig_t'(cfg_wdata);
          REG_TRIG_Z:  about_z = trig_t'(cfg_wdata);
          REG_PIVOT_X: pivot_x = cfg_wdata[PW-1:0];
          REG_PIVOT_Y: pivot_y = cfg_wdata[PW-1:0];
          REG_PIVOT_Z: pivot_z = cfg_wdata[PW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pt.x = in_tdata[23:0];
        pt.y = in_tdata[47:24];
        pt.z = in_tdata[71:48];
        rotated_q.push_back(rotate_about_pivot(pt));
      end
      if (out_tvalid && out_tready) begin
        pt.x = out_tdata[23:0];
        pt.y = out_tdata[47:24];
        pt.z = out_tdata[71:48];
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got x=%0d y=%0d z=%0d",
                   $time, pt.x, pt.y, pt.z);
          errors++;
        end else begin
          want = rotated_q.pop_front();
          check_field("rot_x", want.x, pt.x);
          check_field("rot_y", want.y, pt.y);
          check_field("rot_z", want.z, pt.z);
        end
      end
    end
    in_flight <= rotated_q.size();
    mismatches <= errors;
  end

endmodule

[verif/tb.sv]
module tb;
  import rpac_pkg::*;

  localparam logic [IDXW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDXW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [PW-1:0]   POS_MAX = 24'h7FFFFF;
  localparam logic [PW-1:0]   POS_MIN = 24'h800000;
  localparam logic [CW-1:0]   Q30_ONE = 32'h4000_0000;
  localparam logic [CW-1:0]   Q30_NEG_ONE = 32'hC000_0000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 95;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 12;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [71:0]     in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [71:0]     out_tdata;
  logic            cfg_wr_en;
  logic [IDXW-1:0] cfg_index;
  logic [CFGW-1:0] cfg_wdata;
  int              mismatches;
  int              in_flight;
  bit              no_gaps = 1'b0;
  bit              rcv_quiet = 1'b0;
  bit              rcv_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  point_rotate_about_centroid u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rpac_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  function automatic logic [CW-1:0] corner_q30(input int k);
    case (k)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return Q30_ONE;
    endcase
  endfunction

  function automatic logic [CFGW-1:0] rand_trig();
    logic [CW-1:0] c, s;
    real theta;
    int q;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        theta = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
        c = $rtoi($cos(theta) * 1073741824.0);
        s = $rtoi($sin(theta) * 1073741824.0);
      end
      3: begin
        q = $urandom_range(0, 3);
        c = (q == 0) ? Q30_ONE : (q == 2) ? Q30_NEG_ONE : '0;
        s = (q == 1) ? Q30_ONE : (q == 3) ? Q30_NEG_ONE : '0;
      end
      4: begin
        c = $urandom();
        s = $urandom();
      end
      default: begin
        c = corner_q30($urandom_range(0, 3));
        s = corner_q30($urandom_range(0, 3));
      end
    endcase
    return {c, s};
  endfunction

  function automatic logic [CFGW-1:0] rand_pivot_word();
    logic [CFGW-1:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: ;
      1: w[PW-1:0] = PW'($urandom_range(0, 65535)) - 24'd32768;
      2: w[PW-1:0] = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      default: w[PW-1:0] = '0;
    endcase
    return w;
  endfunction

  function automatic logic [PW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return PW'($urandom());
      4, 5:       return PW'($urandom_range(0, 8191)) - 24'd4096;
      6:          return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      default:    return $urandom_range(0, 1) ? 24'h000001 : 24'hFFFFFF;
    endcase
  endfunction

  task automatic offer_point(input logic [PW-1:0] px, input logic [PW-1:0] py,
                             input logic [PW-1:0] pz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic corner_points();
    offer_point(24'h000000, 24'h000000, 24'h000000);
    offer_point(POS_MAX, POS_MAX, POS_MAX);
    offer_point(POS_MIN, POS_MIN, POS_MIN);
    offer_point(POS_MAX, POS_MIN, POS_MAX);
    offer_point(POS_MIN, POS_MAX, POS_MIN);
    offer_point(24'h000001, 24'hFFFFFF, 24'h000000);
    offer_point(POS_MAX, 24'h000000, POS_MIN);
    offer_point(24'h001000, 24'hFFF000, 24'h7FF000);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFGW-1:0] tx, input logic [CFGW-1:0] ty,
                             input logic [CFGW-1:0] tz, input logic [CFGW-1:0] vx,
                             input logic [CFGW-1:0] vy, input logic [CFGW-1:0] vz);
    write_reg(REG_TRIG_X, tx);
    write_reg(REG_TRIG_Y, ty);
    write_reg(REG_TRIG_Z, tz);
    write_reg(REG_PIVOT_X, vx);
    write_reg(REG_PIVOT_Y, vy);
    write_reg(REG_PIVOT_Z, vz);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver with random back-pressure and one long hold
  initial begin
    int pause;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rcv_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_hold = 1'b0;
      end else begin
        pause = rcv_quiet ? 0 : $urandom_range(0, 16);
        if (pause > 0) begin
          out_tready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int ph;
    int k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_TRIG_X;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: identity rotation about the origin
    corner_points();
    wait_idle();

    // largest positive trig codes and pivot
    load_config({32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
                {32'h7FFF_FFFF, 32'h7FFF_FFFF}, {40'h0, POS_MAX}, {40'h0, POS_MAX},
                {40'h0, POS_MAX});
    corner_points();
    wait_idle();

    // writes to unused indexes must not land anywhere
    write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
    load_config({32'h8000_0000, 32'h8000_0000}, {32'h8000_0000, 32'h8000_0000},
                {32'h8000_0000, 32'h8000_0000}, {{40{1'b1}}, POS_MIN},
                {{40{1'b1}}, POS_MIN}, {{40{1'b1}}, POS_MIN});
    corner_points();

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      load_config(rand_trig(), rand_trig(), rand_trig(), rand_pivot_word(),
                  rand_pivot_word(), rand_pivot_word());
      no_gaps = (ph == 2) || (ph % 4 == 1);
      rcv_quiet = (ph % 4 == 1);
      rcv_hold = (ph == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        offer_point(rand_coord(), rand_coord(), rand_coord());
      end
    end
    wait_idle();

    if (mismatches == 0 && in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
